[hdl/nsf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsf_pkg
// shared types and constants for the fixed-point newton square root
// ---------------------------------------------------------------------------
package nsf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int RADICAND_BITS  = 32;
  localparam int SQRT_BITS      = 32;
  localparam int TOL_BITS       = 32;
  localparam int CAP_BITS       = 6;
  localparam int OUT_TDATA_BITS = 40;
  localparam int CFG_ADDR_BITS  = 1;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 32'd4295;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 6'd40;

  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_TOL = 1'b0;
  localparam cfg_addr_t REG_CAP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_CHECK,
    ST_OUT
  } state_t;

endpackage

[hdl/newton_sqrt_fixed.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// newton_sqrt_fixed
// babylonian square root of an unsigned fixed-point radicand
// ---------------------------------------------------------------------------
// One radicand at a time. The estimate starts at 1.0; each round divides the
// radicand by the estimate with a bit-serial divider while a serial scaler
// forms the tolerance bound, then a check state either ends the run or
// averages estimate and quotient. A zero radicand skips the rounds and goes
// straight to the result. Input is not ready until the result transfer has
// completed.
module newton_sqrt_fixed #(
  parameter int DATA_WIDTH = nsf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nsf_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [nsf_pkg::RADICAND_BITS-1:0]  s_tdata,   // radicand
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [nsf_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // sqrt_value, iterations_used, converged
  input  logic                               cfg_en,
  input  logic [nsf_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [nsf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import nsf_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

  state_t state, state_next;

  logic [TOL_BITS-1:0]   tol;
  logic [CAP_BITS-1:0]   cap;
  logic [DATA_WIDTH-1:0] n;
  logic [DATA_WIDTH-1:0] r;
  logic [CAP_BITS-1:0]   iter;
  logic [SQRT_BITS-1:0]  out_sqrt;
  logic [CAP_BITS-1:0]   out_iter;
  logic                  out_conv;

  logic [DATA_WIDTH-1:0] n_in;
  logic [DATA_WIDTH-1:0] q;
  logic [DATA_WIDTH-1:0] bound;
  logic                  div_done;
  logic                  tol_done;
  logic                  unit_start;
  logic [DATA_WIDTH-1:0] diff;
  logic                  conv_hit;
  logic                  cap_hit;
  logic [DATA_WIDTH-1:0] r_upd;

  nsf_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(unit_start),
    .num  (n),
    .den  (r),
    .quo  (q),
    .done (div_done)
  );

  nsf_tol #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_tol (
    .clk  (clk),
    .rst  (rst),
    .start(unit_start),
    .tol  (tol),
    .r    (r),
    .prod (bound),
    .done (tol_done)
  );

  always_comb begin
    n_in     = DATA_WIDTH'(s_tdata);
    diff     = (r > q) ? (r - q) : (q - r);
    conv_hit = diff <= bound;
    cap_hit  = iter >= cap;
    r_upd    = (r >> 1) + (q >> 1) + {{(DATA_WIDTH-1){1'b0}}, r[0] & q[0]};
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
      cap <= CAP_RESET;
    end else if (cfg_en) begin
      if (cfg_addr == REG_TOL) begin
        tol <= cfg_data[TOL_BITS-1:0];
      end else begin
        cap <= cfg_data[CAP_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unit_start = 1'b0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (n_in == '0) ? ST_OUT : ST_START;
        end
      end
      ST_START: begin
        unit_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done && tol_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (conv_hit || cap_hit) ? ST_OUT : ST_START;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      n        <= n_in;
      r        <= ONE;
      iter     <= '0;
      out_sqrt <= '0;
      out_iter <= '0;
      out_conv <= 1'b1;
    end else if (state == ST_CHECK) begin
      if (conv_hit || cap_hit) begin
        out_sqrt <= SQRT_BITS'(r);
        out_iter <= iter;
        out_conv <= conv_hit;
      end else begin
        r    <= r_upd;
        iter <= iter + CAP_BITS'(1);
      end
    end
  end

  assign m_tdata = {1'b0, out_conv, out_iter, out_sqrt};

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_OUT) |-> iter <= cap)
    else $error("update count past cap");

  a_check_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> (div_done && tol_done))
    else $error("check without finished units");

  a_cap_stop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_conv) |-> out_iter == cap)
    else $error("unconverged result before cap");

endmodule

[hdl/nsf_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsf_div
// radix-2 restoring divider, floor(num * 2^frac / den), saturating
// ---------------------------------------------------------------------------
module nsf_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  output logic [DATA_WIDTH-1:0] quo,
  output logic                  done
);

  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]         num_sh;
  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH-1:0] quo_r;
  logic                  sat;
  logic [CW-1:0]         cnt;
  logic                  busy;

  logic [DATA_WIDTH:0]   rem_sh;
  logic                  ge;
  logic [DATA_WIDTH:0]   rem_next;

  always_comb begin
    rem_sh   = {rem[DATA_WIDTH-1:0], num_sh[NW-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= {num, {FRAC_BITS{1'b0}}};
      rem    <= '0;
      quo_r  <= '0;
      sat    <= 1'b0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= rem_next;
      sat    <= sat | quo_r[DATA_WIDTH-1];
      quo_r  <= {quo_r[DATA_WIDTH-2:0], ge};
    end
  end

  assign quo = sat ? {DATA_WIDTH{1'b1}} : quo_r;

endmodule

[hdl/nsf_tol.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsf_tol
// serial shift-add scaler, floor(tol * r / 2^32), one tolerance bit a cycle
// ---------------------------------------------------------------------------
module nsf_tol #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nsf_pkg::TOL_BITS-1:0] tol,
  input  logic [DATA_WIDTH-1:0]        r,
  output logic [DATA_WIDTH-1:0]        prod,
  output logic                         done
);
  import nsf_pkg::*;

  localparam int CW = $clog2(TOL_BITS + 1);

  logic [TOL_BITS-1:0]   t_sh;
  logic [DATA_WIDTH-1:0] acc;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [DATA_WIDTH:0]   sum;

  assign sum = {1'b0, acc} + (t_sh[0] ? {1'b0, r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(TOL_BITS);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_sh <= tol;
      acc  <= '0;
    end else if (busy) begin
      t_sh <= t_sh >> 1;
      acc  <= sum[DATA_WIDTH:1];
    end
  end

  assign prod = acc;

endmodule
